// File: design/bfsa_pkg.sv
// Package for the best-fit slot allocator.
// Sizes, key layout and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package bfsa_pkg;
    localparam int MAX_RESOURCES = 1024;
    localparam int ADDR_W        = $clog2(MAX_RESOURCES);
    localparam int FILL_W        = $clog2(MAX_RESOURCES + 1);
    localparam int CAP_W         = 16;
    localparam int ID_W          = 10;
    localparam int VAL_W         = 16;
    localparam int CNT_W         = 11;
    localparam int SUM_W         = 26;
    localparam int KEY_W         = CAP_W + ID_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic KIND_ADD     = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic load_item;
        logic ptr_load_fill;
        logic ptr_clear;
        logic ptr_dec;
        logic ptr_inc;
        logic rd_prev;
        logic rd_cur;
        logic rd_next;
        logic wr_shift;
        logic wr_new;
        logic fill_inc;
        logic fill_dec;
        logic capture;
        logic grant_update;
        logic load_result;
    } t_cmd;

    typedef struct packed {
        logic              full;
        logic              ptr_zero;
        logic              ptr_at_fill;
        logic              last;
        logic              entry_after;
        logic              entry_fits;
        logic              out_free;
        logic [FILL_W-1:0] fill;
    } t_status;
endpackage
`default_nettype wire

// File: design/bfsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/bfsa_dp.sv
// Datapath: sorted free list in RAM, scan pointer, counters, result register.
// Depends on bfsa_pkg and bfsa_ram.
`default_nettype none
module bfsa_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bfsa_pkg::t_cmd                  i_cmd,
    output bfsa_pkg::t_status                    o_status,
    input  wire logic [bfsa_pkg::CAP_W-1:0]      i_capacity,
    input  wire logic [bfsa_pkg::ID_W-1:0]       i_resource_id,
    input  wire logic [bfsa_pkg::CAP_W-1:0]      i_request_size,
    input  wire logic [bfsa_pkg::VAL_W-1:0]      i_request_value,
    input  wire logic [bfsa_pkg::ID_W-1:0]       i_request_tag,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_granted,
    output logic      [bfsa_pkg::ID_W-1:0]       o_assigned_resource,
    output logic      [bfsa_pkg::ID_W-1:0]       o_served_tag,
    output logic      [bfsa_pkg::CNT_W-1:0]      o_grant_count,
    output logic      [bfsa_pkg::SUM_W-1:0]      o_value_total
);
    logic [bfsa_pkg::CAP_W-1:0]  r_cap;
    logic [bfsa_pkg::ID_W-1:0]   r_rid;
    logic [bfsa_pkg::CAP_W-1:0]  r_size;
    logic [bfsa_pkg::VAL_W-1:0]  r_val;
    logic [bfsa_pkg::ID_W-1:0]   r_tag;
    logic [bfsa_pkg::ID_W-1:0]   r_hit_id;
    logic                        r_hit;
    logic [bfsa_pkg::FILL_W-1:0] r_ptr;
    logic [bfsa_pkg::FILL_W-1:0] r_fill;
    logic [bfsa_pkg::CNT_W-1:0]  r_count;
    logic [bfsa_pkg::SUM_W-1:0]  r_sum;
    logic                        r_out_valid;

    logic [bfsa_pkg::FILL_W-1:0] ptr_prev;
    logic [bfsa_pkg::FILL_W-1:0] ptr_next;
    logic [bfsa_pkg::ADDR_W-1:0] raddr;
    logic [bfsa_pkg::KEY_W-1:0]  wdata;
    logic [bfsa_pkg::KEY_W-1:0]  rdata;
    logic [bfsa_pkg::CAP_W-1:0]  rd_cap;
    logic [bfsa_pkg::ID_W-1:0]   rd_id;
    logic [bfsa_pkg::SUM_W:0]    sum_add;

    assign ptr_prev = r_ptr - 1'b1;
    assign ptr_next = r_ptr + 1'b1;
    assign rd_cap   = rdata[bfsa_pkg::KEY_W-1:bfsa_pkg::ID_W];
    assign rd_id    = rdata[bfsa_pkg::ID_W-1:0];
    assign wdata    = i_cmd.wr_new ? {r_cap, r_rid} : rdata;
    assign sum_add  = {1'b0, r_sum} + {{(bfsa_pkg::SUM_W+1-bfsa_pkg::VAL_W){1'b0}}, r_val};

    always_comb begin
        raddr = r_ptr[bfsa_pkg::ADDR_W-1:0];
        if (i_cmd.rd_prev) begin
            raddr = ptr_prev[bfsa_pkg::ADDR_W-1:0];
        end else if (i_cmd.rd_next) begin
            raddr = ptr_next[bfsa_pkg::ADDR_W-1:0];
        end
    end

    bfsa_ram #(
        .WIDTH(bfsa_pkg::KEY_W),
        .DEPTH(bfsa_pkg::MAX_RESOURCES)
    ) u_list (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_shift | i_cmd.wr_new),
        .i_waddr(r_ptr[bfsa_pkg::ADDR_W-1:0]),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        o_status.full        = r_fill == bfsa_pkg::FILL_W'(bfsa_pkg::MAX_RESOURCES);
        o_status.ptr_zero    = r_ptr == '0;
        o_status.ptr_at_fill = r_ptr == r_fill;
        o_status.last        = ptr_next >= r_fill;
        o_status.entry_after = (rd_cap > r_cap) || ((rd_cap == r_cap) && (rd_id > r_rid));
        o_status.entry_fits  = rd_cap >= r_size;
        o_status.out_free    = !r_out_valid || i_out_ready;
        o_status.fill        = r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cap  <= i_capacity;
            r_rid  <= i_resource_id;
            r_size <= i_request_size;
            r_val  <= i_request_value;
            r_tag  <= i_request_tag;
        end
        if (i_cmd.capture) begin
            r_hit_id <= rd_id;
        end
        if (i_cmd.ptr_load_fill) begin
            r_ptr <= r_fill;
        end else if (i_cmd.ptr_clear) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= ptr_prev;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= ptr_next;
        end
        if (i_cmd.load_result) begin
            o_granted           <= r_hit;
            o_assigned_resource <= r_hit ? r_hit_id : '0;
            o_served_tag        <= r_tag;
            o_grant_count       <= r_count;
            o_value_total       <= r_sum;
        end
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fill_inc) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_cmd.fill_dec) begin
                r_fill <= r_fill - 1'b1;
            end
            if (i_cmd.load_item) begin
                r_hit <= 1'b0;
            end else if (i_cmd.capture) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.grant_update) begin
                if (r_count != bfsa_pkg::CNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
                r_sum <= sum_add[bfsa_pkg::SUM_W] ? bfsa_pkg::SUM_MAX
                                                  : sum_add[bfsa_pkg::SUM_W-1:0];
            end
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// File: design/bfsa_ctrl.sv
// Controller state machine: sequences insert, search and remove over the list.
// Depends on bfsa_pkg.
`default_nettype none
module bfsa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_kind,
    output logic                   o_in_ready,
    input  wire bfsa_pkg::t_status i_status,
    output bfsa_pkg::t_cmd         o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_REM_RD,
        S_REM_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    if (i_kind == bfsa_pkg::KIND_REQUEST) begin
                        o_cmd.ptr_clear = 1'b1;
                        n_state = S_SRCH_RD;
                    end else if (!i_status.full) begin
                        o_cmd.ptr_load_fill = 1'b1;
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (i_status.ptr_zero) begin
                    o_cmd.wr_new   = 1'b1;
                    o_cmd.fill_inc = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (i_status.entry_after) begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.ptr_dec  = 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    o_cmd.wr_new   = 1'b1;
                    o_cmd.fill_inc = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SRCH_RD: begin
                if (i_status.ptr_at_fill) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK: begin
                if (i_status.entry_fits) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_REM_RD;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state = S_SRCH_RD;
                end
            end
            S_REM_RD: begin
                if (i_status.last) begin
                    o_cmd.fill_dec     = 1'b1;
                    o_cmd.grant_update = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state = S_REM_WR;
                end
            end
            S_REM_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
                n_state = S_REM_RD;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// File: design/best_fit_slot_allocator_unit.sv
// Top level of the best-fit slot allocator.
// Depends on bfsa_pkg, bfsa_ctrl and bfsa_dp.
//
// Keeps free resources in a RAM list sorted by (capacity, id). An add
// transaction walks the list from its tail, shifting larger entries up one
// slot, and writes the new entry when the walk reaches the head or an entry
// that is not larger. An add to a full list is dropped. A request
// transaction scans from the head until the first entry that fits, or to the
// end of the list. It then closes the gap by shifting each following entry
// down one slot, and loads the result register once the output has drained.
// The single RAM port pair (one read, one write per cycle, registered read)
// sets the pace of these walks. A new transaction is taken while a result
// still waits on the output. No clearing pass is needed after reset.
`default_nettype none
module best_fit_slot_allocator_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_kind,
    input  wire logic [bfsa_pkg::CAP_W-1:0]  i_capacity,
    input  wire logic [bfsa_pkg::ID_W-1:0]   i_resource_id,
    input  wire logic [bfsa_pkg::CAP_W-1:0]  i_request_size,
    input  wire logic [bfsa_pkg::VAL_W-1:0]  i_request_value,
    input  wire logic [bfsa_pkg::ID_W-1:0]   i_request_tag,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_granted,
    output logic      [bfsa_pkg::ID_W-1:0]   o_assigned_resource,
    output logic      [bfsa_pkg::ID_W-1:0]   o_served_tag,
    output logic      [bfsa_pkg::CNT_W-1:0]  o_grant_count,
    output logic      [bfsa_pkg::SUM_W-1:0]  o_value_total
);
    bfsa_pkg::t_cmd    cmd;
    bfsa_pkg::t_status status;

    bfsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_kind    (i_kind),
        .o_in_ready(o_in_ready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    bfsa_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_capacity         (i_capacity),
        .i_resource_id      (i_resource_id),
        .i_request_size     (i_request_size),
        .i_request_value    (i_request_value),
        .i_request_tag      (i_request_tag),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_granted          (o_granted),
        .o_assigned_resource(o_assigned_resource),
        .o_served_tag       (o_served_tag),
        .o_grant_count      (o_grant_count),
        .o_value_total      (o_value_total)
    );

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.fill <= bfsa_pkg::FILL_W'(bfsa_pkg::MAX_RESOURCES))
        else $error("free list fill beyond capacity");

    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == bfsa_pkg::KIND_REQUEST) |=> !o_in_ready)
        else $error("request transaction did not occupy the controller");

    a_no_grant_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_assigned_resource == '0))
        else $error("ungranted result carries a resource id");
endmodule
`default_nettype wire
